### src/tds_pkg.sv
// Shared constants, types and helpers of the tridiagonal solver.
`timescale 1ns / 1ps
package tds_pkg;
  localparam int MaxRows = 64;
  localparam int FracBits = 16;
  localparam int RowW = $clog2(MaxRows);
  localparam int SizeW = 7;
  localparam int DataW = 32;
  localparam int NumW = 2 * DataW;
  localparam logic REQ_MATRIX = 1'b0;
  localparam logic REQ_RHS = 1'b1;

  typedef struct packed {
    logic start;
    logic signed [NumW-1:0] num;
    logic signed [DataW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic zero_den;
    logic sat;
    logic signed [DataW-1:0] quo;
  } div_rsp_t;

  function automatic logic [DataW:0] sat_sub(input logic signed [DataW-1:0] a,
                                             input logic signed [DataW-1:0] b);
    logic signed [DataW:0] d;
    d = {a[DataW-1], a} - {b[DataW-1], b};
    if (d[DataW] != d[DataW-1])
      sat_sub = {1'b1, d[DataW], {(DataW-1){~d[DataW]}}};
    else
      sat_sub = {1'b0, d[DataW-1:0]};
  endfunction
endpackage

### src/tds_divider.sv
// Radix-2 signed divider, 64-bit dividend by 32-bit divisor, truncating, saturated.
`timescale 1ns / 1ps
module tds_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  tds_pkg::div_req_t req,
  output tds_pkg::div_rsp_t rsp
);
  import tds_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic              busy_r, busy_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [NumW-1:0]   quo_r, quo_nxt;
  logic [DataW-1:0]  rem_r, rem_nxt;
  logic [DataW-1:0]  den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic              zero_r, zero_nxt;
  logic              done_r, done_nxt;
  logic [DataW:0]    trial;
  logic [DataW:0]    shifted;
  logic [NumW-1:0]   q_final;
  logic signed [NumW:0] q_signed;
  logic              q_sat;
  logic signed [DataW-1:0] q_out;

  always_comb begin
    shifted = {rem_r, quo_r[NumW-1]};
    trial = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = (req.den != '0);
      done_nxt = (req.den == '0);
      zero_nxt = (req.den == '0);
      cnt_nxt = CntW'(NumW);
      quo_nxt = req.num[NumW-1] ? NumW'(-req.num) : req.num;
      den_nxt = req.den[DataW-1] ? DataW'(-req.den) : req.den;
      neg_nxt = req.num[NumW-1] ^ req.den[DataW-1];
      rem_nxt = '0;
    end else if (busy_r) begin
      if (!trial[DataW]) begin
        rem_nxt = trial[DataW-1:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DataW-1:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    zero_r <= zero_nxt;
  end

  always_comb begin
    q_final = quo_r;
    q_signed = neg_r ? -$signed({1'b0, q_final}) : $signed({1'b0, q_final});
    q_sat = 1'b0;
    q_out = q_signed[DataW-1:0];
    if (q_signed > $signed((NumW+1)'(32'h7fffffff))) begin
      q_sat = 1'b1;
      q_out = 32'sh7fffffff;
    end else if (q_signed < -$signed((NumW+1)'(33'h080000000))) begin
      q_sat = 1'b1;
      q_out = 32'sh80000000;
    end
    rsp.done = done_r;
    rsp.zero_den = zero_r;
    rsp.sat = zero_r ? 1'b0 : q_sat;
    rsp.quo = zero_r ? '0 : q_out;
  end
endmodule

### src/tridiagonal_system_solver.sv
// Top level of the tridiagonal system solver.
`timescale 1ns / 1ps
// Thomas-algorithm solver for tridiagonal systems in signed Q16.16.
// Input: pulse start while busy is low. in_req_type 0 stores one matrix
// row (lower, diag, upper) at the next matrix row; 1 stores in_rhs_value
// at the next right-hand-side row. Matrix rows persist across solves.
// The right-hand-side element of the last row starts a solve; busy is
// high throughout. Other transfers leave busy low; the next may follow.
// Config: cfg_valid/cfg_ready write system_size; ready always high, use
// only while idle.
// Solve: row 0 is copied, each later forward row takes two quotients
// through one radix-2 divider (which skips the division on a zero pivot),
// each back row one quotient, then back to idle. Each back row emits one
// result on out_valid, rows n-1 down to 0. The divider sets the rate.
// Results show for one cycle; the receiver cannot stall.
// Reset clears counters, error flag and size (64); stores are undefined
// until written.
module tridiagonal_system_solver (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic signed [31:0]           in_lower_coef,
  input  logic signed [31:0]           in_diag_coef,
  input  logic signed [31:0]           in_upper_coef,
  input  logic signed [31:0]           in_rhs_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [6:0]                   cfg_system_size,
  output logic                         out_valid,
  output logic signed [31:0]           out_solution_value,
  output logic [5:0]                   out_row_index,
  output logic                         out_last_result,
  output logic                         out_pivot_error,
  output logic                         out_saturated
);
  import tds_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_F_RD = 4'd1;
  localparam logic [3:0] ST_F_D1 = 4'd2;
  localparam logic [3:0] ST_F_W1 = 4'd3;
  localparam logic [3:0] ST_F_D2 = 4'd4;
  localparam logic [3:0] ST_F_W2 = 4'd5;
  localparam logic [3:0] ST_B_RD = 4'd6;
  localparam logic [3:0] ST_B_MUL = 4'd7;
  localparam logic [3:0] ST_B_DIV = 4'd8;
  localparam logic [3:0] ST_B_WT = 4'd9;
  localparam logic [3:0] ST_F_MUL = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic signed [DataW-1:0] lower_mem [MaxRows];
  logic signed [DataW-1:0] diag_mem [MaxRows];
  logic signed [DataW-1:0] upper_mem [MaxRows];
  logic signed [DataW-1:0] pivot_mem [MaxRows];
  logic signed [DataW-1:0] work_mem [MaxRows];
  logic                    sat_mem [MaxRows];

  logic [3:0]       state_r, state_nxt;
  logic [SizeW-1:0] size_r;
  logic [SizeW-1:0] mcnt_r, rcnt_r;
  logic             err_r;
  logic [RowW-1:0]  row_r, row_nxt;
  logic [SizeW-1:0] n_use;
  logic [SizeW-1:0] mrow, rrow;

  // read ports (registered)
  logic [RowW-1:0]         rd_addr;
  logic signed [DataW-1:0] lower_q, diag_q, upper_q, work_q;
  logic                    sat_q;
  // previous row values carried in registers
  logic signed [DataW-1:0] piv_prev_r, f_prev_r, x_prev_r, piv_cur_r;
  logic signed [DataW-1:0] t_val_r;
  logic                    s_r;
  logic signed [NumW-1:0]  prod_r;

  div_req_t dreq;
  div_rsp_t drsp;
  logic [DataW:0] sub_res;

  tds_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_ready = 1'b1;
  assign busy = (state_r != ST_IDLE);

  always_comb begin
    if (size_r == '0) n_use = SizeW'(1);
    else if (size_r > SizeW'(MaxRows)) n_use = SizeW'(MaxRows);
    else n_use = size_r;
    mrow = (mcnt_r < n_use) ? mcnt_r : '0;
    rrow = (rcnt_r < n_use) ? rcnt_r : '0;
  end

  wire accept = start && !busy;
  wire solve_go = accept && (in_req_type == REQ_RHS) && (rrow + 1'b1 >= n_use);
  wire [RowW-1:0] last_row = RowW'(n_use - 1'b1);

  // input writes and registered reads
  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_MATRIX) begin
      lower_mem[RowW'(mrow)] <= in_lower_coef;
      diag_mem[RowW'(mrow)] <= in_diag_coef;
      upper_mem[RowW'(mrow)] <= in_upper_coef;
    end
    lower_q <= lower_mem[rd_addr];
    diag_q <= diag_mem[rd_addr];
    upper_q <= upper_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;
    rd_addr = row_r;
    dreq = '0;
    sub_res = sat_sub((state_r == ST_F_D2) ? work_q : diag_q, drsp.quo);
    unique case (state_r)
      ST_IDLE: if (solve_go) begin
        state_nxt = ST_F_RD;
        row_nxt = '0;
      end
      ST_F_RD: ;
      ST_F_MUL: begin
        dreq.start = 1'b1;
        dreq.num = prod_r;
        dreq.den = piv_prev_r;
        state_nxt = ST_F_D1;
      end
      ST_F_D1: if (drsp.done) state_nxt = ST_F_W1;
      ST_F_W1: begin
        dreq.start = 1'b1;
        dreq.num = prod_r;
        dreq.den = piv_prev_r;
        state_nxt = ST_F_D2;
      end
      ST_F_D2: if (drsp.done) state_nxt = ST_F_W2;
      ST_F_W2: begin
        if (row_r == last_row) begin
          state_nxt = ST_B_RD;
        end else begin
          row_nxt = row_r + 1'b1;
          state_nxt = ST_F_RD;
          rd_addr = row_r + 1'b1;
        end
      end
      ST_B_RD: state_nxt = ST_B_MUL;
      ST_B_MUL: state_nxt = ST_B_DIV;
      ST_B_DIV: begin
        dreq.start = 1'b1;
        dreq.num = prod_r;
        dreq.den = piv_cur_r;
        state_nxt = ST_B_WT;
      end
      ST_B_WT: if (drsp.done) begin
        if (row_r == '0) state_nxt = ST_DONE;
        else begin
          row_nxt = row_r - 1'b1;
          rd_addr = row_r - 1'b1;
          state_nxt = ST_B_RD;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Forward sweep per row i: read row i; i==0 copies; otherwise
  // t1 = upper[i-1]*lower[i]/piv[i-1], t2 = f[i-1]*lower[i]/piv[i-1].
  logic signed [DataW-1:0] upper_prev_r, lower_cur_r;
  logic signed [DataW-1:0] pivot_rd_q, f_rd_q;
  logic signed [NumW-1:0]  f_scaled, ux_prod;

  always_comb begin
    f_scaled = NumW'(f_rd_q) <<< FracBits;
    ux_prod = upper_q * x_prev_r;
    if (row_r == last_row) ux_prod = '0;
  end

  always_ff @(posedge clk) begin
    pivot_rd_q <= pivot_mem[rd_addr];
    f_rd_q <= work_mem[rd_addr];
    sat_q <= sat_mem[rd_addr];
    work_q <= (accept && in_req_type == REQ_RHS && RowW'(rrow) == rd_addr) ? in_rhs_value
                                                                            : work_mem[rd_addr];
    if (accept && in_req_type == REQ_RHS) work_mem[RowW'(rrow)] <= in_rhs_value;
    out_valid <= 1'b0;
    unique case (state_r)
      ST_F_RD: begin
        lower_cur_r <= lower_q;
        s_r <= 1'b0;
        prod_r <= upper_prev_r * lower_q;
      end
      ST_F_D1: if (drsp.done) begin
        t_val_r <= sub_res[DataW-1:0];
        s_r <= s_r | drsp.sat | sub_res[DataW];
        prod_r <= f_prev_r * lower_cur_r;
      end
      ST_F_D2: if (drsp.done) begin
        f_prev_r <= sub_res[DataW-1:0];
        s_r <= s_r | drsp.sat | sub_res[DataW];
      end
      ST_F_W2: begin
        pivot_mem[row_r] <= t_val_r;
        work_mem[row_r] <= f_prev_r;
        sat_mem[row_r] <= s_r;
        piv_prev_r <= t_val_r;
        upper_prev_r <= upper_q;
      end
      ST_B_MUL: begin
        piv_cur_r <= pivot_rd_q;
        prod_r <= f_scaled - ux_prod;
        s_r <= sat_q;
      end
      ST_B_WT: if (drsp.done) begin
        x_prev_r <= drsp.quo;
        out_valid <= 1'b1;
        out_solution_value <= drsp.quo;
        out_row_index <= 6'(row_r);
        out_last_result <= (row_r == '0);
        out_saturated <= s_r | drsp.sat;
      end
      default: ;
    endcase
    // row 0 handling: pivot=diag, f=work, no division
    if (state_r == ST_F_RD && row_r == '0) begin
      t_val_r <= diag_q;
      f_prev_r <= work_q;
    end
  end

  logic err_nxt;
  always_comb begin
    err_nxt = err_r;
    if (state_r == ST_IDLE && solve_go) err_nxt = 1'b0;
    if (drsp.done && drsp.zero_den && state_r != ST_IDLE) err_nxt = 1'b1;
  end
  assign out_pivot_error = err_r;

  logic [3:0] state_fix;
  always_comb begin
    state_fix = state_nxt;
    if (state_r == ST_F_RD) state_fix = (row_r == '0) ? ST_F_W2 : ST_F_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      size_r <= SizeW'(MaxRows);
      mcnt_r <= '0;
      rcnt_r <= '0;
      err_r <= 1'b0;
      row_r <= '0;
    end else begin
      state_r <= state_fix;
      row_r <= row_nxt;
      err_r <= err_nxt;
      if (cfg_valid && cfg_ready) size_r <= cfg_system_size;
      if (accept && in_req_type == REQ_MATRIX)
        mcnt_r <= (mrow + 1'b1 >= n_use) ? '0 : mrow + 1'b1;
      if (accept && in_req_type == REQ_RHS)
        rcnt_r <= (rrow + 1'b1 >= n_use) ? '0 : rrow + 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside solve");
  a_start_solve: assert property (@(posedge clk) disable iff (!rst_n)
    solve_go |=> busy) else $error("solve not started");
  a_last_row0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> out_row_index == '0) else $error("bad last");
`endif
endmodule

### test/tb_top.sv
// Testbench for the tridiagonal system solver: directed and random stimulus checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import tds_pkg::*;

  typedef struct {
    logic req;
    logic signed [31:0] lo;
    logic signed [31:0] di;
    logic signed [31:0] up;
    logic signed [31:0] rhs;
    int gap;
  } row_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic [5:0] row;
    logic last;
    logic perr;
    logic sat;
  } sol_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_req_type = 0;
  logic signed [31:0] in_lower_coef = 0, in_diag_coef = 0;
  logic signed [31:0] in_upper_coef = 0, in_rhs_value = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [6:0] cfg_system_size = 0;
  logic out_valid;
  logic signed [31:0] out_solution_value;
  logic [5:0] out_row_index;
  logic out_last_result, out_pivot_error, out_saturated;

  tridiagonal_system_solver dut (.*);

  always #1 clk = ~clk;

  row_item_t pending[$];
  sol_t solutions_due[$];
  int mismatches = 0;
  int fed = 0;
  int queued = 0;
  longint cycles = 0;

  logic signed [31:0] m_lo[MaxRows], m_di[MaxRows], m_up[MaxRows];
  logic signed [31:0] m_piv[MaxRows], m_f[MaxRows];
  int mat_row = 0, rhs_row = 0;
  logic [6:0] size_reg = 64;
  logic perr_flag;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v, inout logic s);
    if (v > 66'sd2147483647) begin
      s = 1;
      return 32'sh7fffffff;
    end
    if (v < -66'sd2147483648) begin
      s = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [65:0] num,
                                                input logic signed [31:0] p, inout logic s);
    logic signed [65:0] q;
    if (p == 0) begin
      perr_flag = 1;
      return 0;
    end
    q = num / 66'(p);
    return clamp32(q, s);
  endfunction

  function automatic int rows_used();
    if (size_reg == 0) return 1;
    if (size_reg > MaxRows) return MaxRows;
    return size_reg;
  endfunction

  task automatic solve_system(input int n);
    logic signed [31:0] f[MaxRows], x[MaxRows], t;
    logic sflag[MaxRows];
    logic s;
    logic signed [65:0] num;
    sol_t r;
    perr_flag = 0;
    m_piv[0] = m_di[0];
    f[0] = m_f[0];
    sflag[0] = 0;
    for (int i = 1; i < n; i++) begin
      s = 0;
      t = fx_div(66'(m_up[i-1]) * 66'(m_lo[i]), m_piv[i-1], s);
      m_piv[i] = clamp32(66'(m_di[i]) - 66'(t), s);
      t = fx_div(66'(f[i-1]) * 66'(m_lo[i]), m_piv[i-1], s);
      f[i] = clamp32(66'(m_f[i]) - 66'(t), s);
      sflag[i] = s;
    end
    s = sflag[n-1];
    x[n-1] = fx_div(66'(f[n-1]) <<< FracBits, m_piv[n-1], s);
    sflag[n-1] = s;
    for (int i = n - 2; i >= 0; i--) begin
      num = (66'(f[i]) <<< FracBits) - 66'(m_up[i]) * 66'(x[i+1]);
      s = sflag[i];
      x[i] = fx_div(num, m_piv[i], s);
      sflag[i] = s;
    end
    for (int k = n - 1; k >= 0; k--) begin
      r.x = x[k];
      r.row = k[5:0];
      r.last = (k == 0);
      r.perr = perr_flag;
      r.sat = sflag[k];
      solutions_due = {solutions_due, r};
    end
  endtask

  task automatic predict(input row_item_t it);
    int n, r;
    n = rows_used();
    if (it.req == REQ_MATRIX) begin
      r = (mat_row < n) ? mat_row : 0;
      m_lo[r] = it.lo;
      m_di[r] = it.di;
      m_up[r] = it.up;
      mat_row = (r + 1 >= n) ? 0 : r + 1;
    end else begin
      r = (rhs_row < n) ? rhs_row : 0;
      m_f[r] = it.rhs;
      if (r + 1 >= n) begin
        rhs_row = 0;
        solve_system(n);
      end else begin
        rhs_row = r + 1;
      end
    end
  endtask

  // driver
  int wait_cnt = 0;
  logic busy_at_edge = 1;
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy_at_edge) begin
        start <= 0;
      end else if (!start && pending.size() > 0) begin
        if (wait_cnt < pending[0].gap) begin
          wait_cnt <= wait_cnt + 1;
        end else begin
          wait_cnt <= 0;
          in_req_type <= pending[0].req;
          in_lower_coef <= pending[0].lo;
          in_diag_coef <= pending[0].di;
          in_upper_coef <= pending[0].up;
          in_rhs_value <= pending[0].rhs;
          pending.pop_front();
          start <= 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (rst_n && start && !busy) fed <= fed + 1;
  end

  // monitor
  always @(posedge clk) begin
    sol_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (solutions_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result row %0d", out_row_index);
      end else begin
        e = solutions_due.pop_front();
        if (out_solution_value !== e.x || out_row_index !== e.row ||
            out_last_result !== e.last || out_pivot_error !== e.perr ||
            out_saturated !== e.sat) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display({"mismatch exp x=%h row=%0d last=%b perr=%b sat=%b",
                      " got x=%h row=%0d last=%b perr=%b sat=%b"},
                     e.x, e.row, e.last, e.perr, e.sat, out_solution_value, out_row_index,
                     out_last_result, out_pivot_error, out_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 5000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coef(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      default: return $signed($urandom_range(32'h8000, 32'h80000));
    endcase
  endfunction

  task automatic queue_item(input row_item_t it);
    it.gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    predict(it);
    pending = {pending, it};
    queued++;
  endtask

  task automatic push_row(input int mode);
    row_item_t it;
    it.req = REQ_MATRIX;
    it.lo = rand_coef(mode == 2 ? 1 : mode);
    it.di = rand_coef(mode);
    it.up = rand_coef(mode == 2 ? 1 : mode);
    it.rhs = $urandom;
    queue_item(it);
  endtask

  task automatic push_rhs(input logic signed [31:0] v);
    row_item_t it;
    it.req = REQ_RHS;
    it.lo = $urandom;
    it.di = $urandom;
    it.up = $urandom;
    it.rhs = v;
    queue_item(it);
  endtask

  task automatic drain();
    wait (pending.size() == 0 && fed == queued);
    wait (solutions_due.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_size(input logic [6:0] v);
    @(negedge clk);
    cfg_system_size <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    size_reg = v;
  endtask

  row_item_t d;
  int n, mode;
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: sizes 1, 0, 3 and 2, extremes and zero pivot
    set_size(1);
    d = '{REQ_MATRIX, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0};
    queue_item(d);
    push_rhs(32'sh7fffffff);
    push_rhs(32'sh80000000);
    d = '{REQ_MATRIX, 32'sh7fffffff, 0, 32'sh7fffffff, 0, 0};
    queue_item(d);
    push_rhs(32'h00010000);
    d = '{REQ_MATRIX, 0, 32'sh80000000, 0, 0, 0};
    queue_item(d);
    push_rhs(-1);
    drain();
    set_size(0);
    push_row(1);
    push_rhs($urandom);
    drain();
    set_size(3);
    d = '{REQ_MATRIX, 0, 32'h00010000, 32'h00010000, 0, 0};
    queue_item(d);
    d = '{REQ_MATRIX, 32'h00010000, 32'h00010000, 32'h7fffffff, 0, 0};
    queue_item(d);
    d = '{REQ_MATRIX, 32'h80000000, 32'h00020000, 0, 0, 0};
    queue_item(d);
    push_rhs(32'h00010000);
    push_rhs(32'h7fffffff);
    push_rhs(32'h80000000);
    drain();
    set_size(2);
    push_row(0);
    push_row(0);
    push_row(0);
    push_rhs($urandom);
    push_rhs($urandom);
    drain();
    // random phases
    while (queued < 290) begin
      case ($urandom_range(0, 5))
        0: n = 64;
        1: n = $urandom_range(65, 127);
        default: n = $urandom_range(1, 8);
      endcase
      if (queued > 180) n = $urandom_range(1, 8);
      set_size(n[6:0]);
      n = rows_used();
      mode = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) push_row(mode);
      for (int s = 0; s < 1 + (n < 9 ? $urandom_range(0, 3) : 0); s++)
        for (int i = 0; i < n; i++) push_rhs(mode == 0 ? $urandom : rand_coef(1));
      if ($urandom_range(0, 3) == 0) push_row(mode);
      if ($urandom_range(0, 3) == 0) push_rhs($urandom);
      drain();
    end
    if (mismatches == 0 && solutions_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
